// ===== rtl/double_ended_queue_unit_macros.svh =====
// Assertion macros shared by the double-ended queue RTL.
// Each macro expands to one labeled concurrent assertion that is disabled
// while reset is high and reports through $error.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define DQU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons is checked with the non-overlapping |=> operator.
`define DQU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dqu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqu_pkg: shared definitions for the double-ended queue
// Sizes, request and status codes, and the per-cell command word.
// ----------------------------------------------------------------------------
package dqu_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int REQ_W  = 3;
   localparam int STAT_W = 2;

   localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd5;
   localparam logic [REQ_W-1:0] REQ_STATUS     = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE      = 3'd7;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

   // One command per cell and cycle; at most one bit is set.
   typedef struct packed {
      logic shift_right;
      logic shift_left;
      logic load;
   } cell_cmd_type;

endpackage

// ===== rtl/dqu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqu_cell: one storage cell of the queue row
// Holds one word, takes a neighbor's word on a shift or the pushed word on a
// load, and compares its word against the search key.
// ----------------------------------------------------------------------------
module dqu_cell (
   input  logic                                clock,
   input  dqu_pkg::cell_cmd_type               cmd,
   input  logic signed [dqu_pkg::DATA_W-1:0]   left_data,
   input  logic signed [dqu_pkg::DATA_W-1:0]   right_data,
   input  logic signed [dqu_pkg::DATA_W-1:0]   wr_value,
   input  logic signed [dqu_pkg::DATA_W-1:0]   key,
   input  logic                                occupied,
   output logic signed [dqu_pkg::DATA_W-1:0]   data,
   output logic                                match
);

   logic signed [dqu_pkg::DATA_W-1:0] data_ff;
   logic signed [dqu_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_right) begin
         data_in = left_data;
      end else if (cmd.shift_left) begin
         data_in = right_data;
      end else if (cmd.load) begin
         data_in = wr_value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = occupied && (data_ff == key);

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue of signed words
// A row of cells holds the queue with the front entry in cell zero.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_ready, req_type, req_item_value) takes
// one word per handshake: push front or rear, pop front or rear, search,
// clear, or a status-only request. The response channel (rsp_valid,
// rsp_ready, rsp_*) returns exactly one word per request, carrying the popped
// or matched value, a status code, the front and rear peeks and the count.
// A request is executed in the cycle it is accepted; its response is valid
// from the next cycle on. Every cell of the row shifts, loads or compares in
// the accepting cycle, which lets the block take one request per cycle for
// as long as responses are taken.
// The response register is the only buffer between the channels: while a
// response waits on rsp_ready low, req_ready stays low and the queue state is
// frozen; the request arriving in the cycle the response leaves is accepted.
// Reset empties the queue and drops any pending response. Cell contents are
// not cleared; cells beyond the count never reach a response.
// ----------------------------------------------------------------------------
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dqu_pkg::REQ_W-1:0]           req_type,
   input  logic signed [dqu_pkg::DATA_W-1:0]   req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dqu_pkg::DATA_W-1:0]   rsp_result_value,
   output logic [dqu_pkg::STAT_W-1:0]          rsp_status,
   output logic signed [dqu_pkg::DATA_W-1:0]   rsp_front_value,
   output logic signed [dqu_pkg::DATA_W-1:0]   rsp_rear_value,
   output logic [dqu_pkg::CNT_W-1:0]           rsp_entry_count
);

   // Queue control state.
   logic [dqu_pkg::CNT_W-1:0]          count_ff;
   logic [dqu_pkg::CNT_W-1:0]          count_in;
   logic signed [dqu_pkg::DATA_W-1:0]  rear_ff;
   logic signed [dqu_pkg::DATA_W-1:0]  rear_in;

   // Response register.
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic signed [dqu_pkg::DATA_W-1:0]  result_ff;
   logic signed [dqu_pkg::DATA_W-1:0]  result_in;
   logic [dqu_pkg::STAT_W-1:0]         status_ff;
   logic [dqu_pkg::STAT_W-1:0]         status_in;
   logic signed [dqu_pkg::DATA_W-1:0]  front_out_ff;
   logic signed [dqu_pkg::DATA_W-1:0]  front_out_in;
   logic signed [dqu_pkg::DATA_W-1:0]  rear_out_ff;
   logic signed [dqu_pkg::DATA_W-1:0]  rear_out_in;
   logic [dqu_pkg::CNT_W-1:0]          count_out_ff;

   // Cell row.
   logic signed [dqu_pkg::DATA_W-1:0]  cell_q [dqu_pkg::DEPTH];
   dqu_pkg::cell_cmd_type              cell_cmd [dqu_pkg::DEPTH];
   logic [dqu_pkg::DEPTH-1:0]          occupied;
   logic [dqu_pkg::DEPTH-1:0]          match_vec;

   logic                               req_fire;
   logic                               full;
   logic                               empty;
   logic                               any_match;
   logic                               do_push_front;
   logic                               do_push_rear;
   logic                               do_pop_front;
   logic                               do_pop_rear;
   logic signed [dqu_pkg::DATA_W-1:0]  front_next;
   logic [dqu_pkg::IDX_W-1:0]          prev_idx;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == dqu_pkg::CNT_W'(dqu_pkg::DEPTH));
   assign empty     = (count_ff == '0);
   assign any_match = |match_vec;

   // The entry just before the tail sits at count - 2; when the queue is full
   // the low bits of the count are zero and the subtraction wraps, as intended.
   assign prev_idx = count_ff[dqu_pkg::IDX_W-1:0] - dqu_pkg::IDX_W'(2);

   // Request decode and next-state logic.
   always_comb begin
      do_push_front = 1'b0;
      do_push_rear  = 1'b0;
      do_pop_front  = 1'b0;
      do_pop_rear   = 1'b0;
      count_in      = count_ff;
      rear_in       = rear_ff;
      result_in     = '0;
      status_in     = dqu_pkg::ST_OK;
      front_next    = cell_q[0];

      unique case (req_type) inside
         dqu_pkg::REQ_PUSH_FRONT: begin
            if (full) begin
               status_in = dqu_pkg::ST_FULL;
            end else begin
               do_push_front = req_fire;
               count_in      = count_ff + dqu_pkg::CNT_W'(1);
               front_next    = req_item_value;
               if (empty) begin
                  rear_in = req_item_value;
               end
            end
         end
         dqu_pkg::REQ_PUSH_REAR: begin
            if (full) begin
               status_in = dqu_pkg::ST_FULL;
            end else begin
               do_push_rear = req_fire;
               count_in     = count_ff + dqu_pkg::CNT_W'(1);
               rear_in      = req_item_value;
               if (empty) begin
                  front_next = req_item_value;
               end
            end
         end
         dqu_pkg::REQ_POP_FRONT: begin
            if (empty) begin
               status_in = dqu_pkg::ST_EMPTY;
            end else begin
               do_pop_front = req_fire;
               count_in     = count_ff - dqu_pkg::CNT_W'(1);
               result_in    = cell_q[0];
               front_next   = cell_q[1];
            end
         end
         dqu_pkg::REQ_POP_REAR: begin
            if (empty) begin
               status_in = dqu_pkg::ST_EMPTY;
            end else begin
               do_pop_rear = req_fire;
               count_in    = count_ff - dqu_pkg::CNT_W'(1);
               result_in   = rear_ff;
               rear_in     = cell_q[prev_idx];
            end
         end
         dqu_pkg::REQ_SEARCH: begin
            if (any_match) begin
               result_in = req_item_value;
            end else begin
               status_in = dqu_pkg::ST_NOTFOUND;
            end
         end
         dqu_pkg::REQ_CLEAR: begin
            count_in = '0;
         end
         dqu_pkg::REQ_STATUS, dqu_pkg::REQ_SPARE: begin
         end
         default: begin
         end
      endcase

      if (count_in == '0) begin
         front_out_in = '0;
         rear_out_in  = '0;
      end else begin
         front_out_in = front_next;
         rear_out_in  = rear_in;
      end
   end

   // Cell commands: the whole row shifts toward the rear on a front push and
   // toward the front on a front pop; a rear push loads the first free cell.
   // A rear pop only shortens the count.
   genvar gi;
   generate
      for (gi = 0; gi < dqu_pkg::DEPTH; gi++) begin : g_cell
         logic signed [dqu_pkg::DATA_W-1:0] left_word;
         logic signed [dqu_pkg::DATA_W-1:0] right_word;

         if (gi == 0) begin : g_first
            assign left_word = req_item_value;
         end else begin : g_inner_left
            assign left_word = cell_q[gi-1];
         end

         if (gi == dqu_pkg::DEPTH - 1) begin : g_last
            assign right_word = '0;
         end else begin : g_inner_right
            assign right_word = cell_q[gi+1];
         end

         assign occupied[gi]             = (count_ff > dqu_pkg::CNT_W'(gi));
         assign cell_cmd[gi].shift_right = do_push_front;
         assign cell_cmd[gi].shift_left  = do_pop_front;
         assign cell_cmd[gi].load        = do_push_rear &&
            (count_ff[dqu_pkg::IDX_W-1:0] == dqu_pkg::IDX_W'(gi));

         dqu_cell u_cell (
            .clock      (clock),
            .cmd        (cell_cmd[gi]),
            .left_data  (left_word),
            .right_data (right_word),
            .wr_value   (req_item_value),
            .key        (req_item_value),
            .occupied   (occupied[gi]),
            .data       (cell_q[gi]),
            .match      (match_vec[gi])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state, reset synchronously.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            count_ff <= count_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rear_ff      <= rear_in;
         result_ff    <= result_in;
         status_ff    <= status_in;
         front_out_ff <= front_out_in;
         rear_out_ff  <= rear_out_in;
         count_out_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = result_ff;
   assign rsp_status       = status_ff;
   assign rsp_front_value  = front_out_ff;
   assign rsp_rear_value   = rear_out_ff;
   assign rsp_entry_count  = count_out_ff;

   // Checks on the queue's own bookkeeping.
   `DQU_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      count_ff <= dqu_pkg::CNT_W'(dqu_pkg::DEPTH), "entry count exceeds capacity")
   `DQU_ASSERT_SAME(a_rsp_count_match, clock, reset, rsp_valid_ff,
      count_out_ff == count_ff, "reported count differs from held count")
   `DQU_ASSERT_SAME(a_empty_peeks_zero, clock, reset,
      rsp_valid_ff && (count_out_ff == '0),
      (front_out_ff == '0) && (rear_out_ff == '0), "empty queue reports nonzero peeks")
   `DQU_ASSERT_NEXT(a_full_push_drops, clock, reset,
      req_fire && full && ((req_type == dqu_pkg::REQ_PUSH_FRONT) ||
      (req_type == dqu_pkg::REQ_PUSH_REAR)),
      $stable(count_ff) && (status_ff == dqu_pkg::ST_FULL), "push on full queue not dropped")

endmodule
